// ===== rtl/core/tnid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tnid_pkg;

  localparam int unsigned MaxEntriesDef = 1024;
  localparam int unsigned NameBytesDef  = 20;
  localparam int unsigned FieldBytes    = 20;
  localparam int unsigned NameW         = 8 * FieldBytes;
  localparam int unsigned NumW          = 11;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned StatW         = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QNAME = 2'd1,
    CMD_QNUM  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/tnid_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tnid_in_if import tnid_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [63:0]     name_head;
  logic [63:0]     name_middle;
  logic [31:0]     name_tail;
  logic [NumW-1:0] entry_number;

  modport source (output valid, command, name_head, name_middle, name_tail, entry_number,
                  input ready);
  modport sink   (input valid, command, name_head, name_middle, name_tail, entry_number,
                  output ready);
endinterface

interface tnid_out_if import tnid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [NumW-1:0]  found_number;
  logic [63:0]      out_head;
  logic [63:0]      out_middle;
  logic [31:0]      out_tail;

  modport source (output valid, status, found_number, out_head, out_middle, out_tail,
                  input ready);
  modport sink   (input valid, status, found_number, out_head, out_middle, out_tail,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/two_way_name_index_dictionary_unit.sv =====
// Clear and rejected commands skip to the reply stage; a number query reads the name.
// Name query: binary search over the sorted order, each step reading the order,
// then the name, then comparing; a last compare checks a slot inside the table.
// Load: the same search, then the sorted-order entries past the slot shift up.
// One word at a time; the single compare unit and the memory read ports set the pace.
// Reset clears the entry count and control; the memories hold no reset value.
`timescale 1ns / 1ps
`default_nettype none
module two_way_name_index_dictionary_unit import tnid_pkg::*; #(
  parameter int unsigned MaxEntries = MaxEntriesDef,
  parameter int unsigned NameBytes  = NameBytesDef
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  tnid_in_if.sink    in_i,
  tnid_out_if.source out_o
);

  localparam int unsigned IW   = $clog2(MaxEntries);
  localparam int unsigned CW   = $clog2(MaxEntries + 1);
  localparam int unsigned CMPW = (CW > NumW) ? CW : NumW;

  typedef enum logic [3:0] {
    S_IDLE, S_NRD, S_SRCH, S_ORD, S_NAME, S_CMP, S_SH, S_SHWR, S_FIN
  } state_e;

  state_e          state_q;
  cmd_e            cmd_q;
  logic [NameW-1:0] key_q, key_norm;
  logic [CW-1:0]   count_q, lo_q, hi_q, mid_q, idx_q, mid_c;
  logic [IW-1:0]   ordv_q;
  logic            fin_q;
  status_e         res_stat_q;
  logic [NumW-1:0] res_num_q;
  logic [NameW-1:0] res_name_q;
  logic            out_valid_q;
  status_e         out_stat_q;
  logic [NumW-1:0] out_num_q;
  logic [NameW-1:0] out_name_q;

  logic             in_acc, num_ok;
  cmd_e             in_cmd;
  logic [NameW-1:0] raw_name;
  logic             name_we, name_re, ord_we, ord_re;
  logic [IW-1:0]    name_waddr, name_raddr, ord_waddr, ord_wdata, ord_raddr;
  logic [NameW-1:0] name_rdata;
  logic [IW-1:0]    ord_rdata;
  cmp_res_t         cmp_res;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_cmd     = cmd_e'(in_i.command);
  assign raw_name   = {in_i.name_head, in_i.name_middle, in_i.name_tail};
  assign num_ok     = (in_i.entry_number != '0) &&
                      (CMPW'(in_i.entry_number) <= CMPW'(count_q));
  assign mid_c      = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

  // a name stops at its first zero byte or past the configured length
  always_comb begin
    logic ended;
    ended = 1'b0;
    key_norm = '0;
    for (int k = 0; k < FieldBytes; k++) begin
      if (k >= NameBytes || raw_name[NameW-1-8*k -: 8] == 8'h00) ended = 1'b1;
      key_norm[NameW-1-8*k -: 8] = ended ? 8'h00 : raw_name[NameW-1-8*k -: 8];
    end
  end

  always_comb begin
    name_we    = 1'b0;
    name_waddr = count_q[IW-1:0];
    name_re    = 1'b0;
    name_raddr = ord_rdata;
    ord_we     = 1'b0;
    ord_waddr  = idx_q[IW-1:0];
    ord_wdata  = ord_rdata;
    ord_re     = 1'b0;
    ord_raddr  = mid_c[IW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_LOAD && CMPW'(count_q) < CMPW'(MaxEntries)) begin
          name_we = 1'b1;
        end
        if (in_acc && in_cmd == CMD_QNUM && num_ok) begin
          name_re    = 1'b1;
          name_raddr = IW'(in_i.entry_number - NumW'(1));
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          ord_re = 1'b1;
        end else if (cmd_q == CMD_QNAME && lo_q < count_q) begin
          ord_re    = 1'b1;
          ord_raddr = lo_q[IW-1:0];
        end
      end
      S_ORD: name_re = 1'b1;
      S_SH: begin
        if (idx_q > lo_q) begin
          ord_re    = 1'b1;
          ord_raddr = IW'(idx_q - CW'(1));
        end else begin
          ord_we    = 1'b1;
          ord_waddr = lo_q[IW-1:0];
          ord_wdata = count_q[IW-1:0];
        end
      end
      S_SHWR: ord_we = 1'b1;
      default: ;
    endcase
  end

  tnid_mem #(.Depth(MaxEntries), .IdxW(IW)) u_mem (
    .clk_i,
    .name_we_i    (name_we),
    .name_waddr_i (name_waddr),
    .name_wdata_i (key_norm),
    .name_re_i    (name_re),
    .name_raddr_i (name_raddr),
    .name_rdata_o (name_rdata),
    .ord_we_i     (ord_we),
    .ord_waddr_i  (ord_waddr),
    .ord_wdata_i  (ord_wdata),
    .ord_re_i     (ord_re),
    .ord_raddr_i  (ord_raddr),
    .ord_rdata_o  (ord_rdata)
  );

  tnid_cmp u_cmp (
    .clk_i,
    .en_i  (state_q == S_NAME),
    .a_i   (name_rdata),
    .b_i   (key_q),
    .res_o (cmp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_LOAD;
      fin_q       <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      idx_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != S_FIN) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q      <= in_cmd;
            key_q      <= key_norm;
            lo_q       <= '0;
            hi_q       <= count_q;
            fin_q      <= 1'b0;
            res_stat_q <= ST_OK;
            res_num_q  <= '0;
            res_name_q <= '0;
            unique case (in_cmd)
              CMD_LOAD: begin
                if (CMPW'(count_q) >= CMPW'(MaxEntries)) begin
                  res_stat_q <= ST_FULL;
                  state_q    <= S_FIN;
                end else begin
                  state_q <= S_SRCH;
                end
              end
              CMD_QNAME: state_q <= S_SRCH;
              CMD_QNUM: begin
                if (num_ok) begin
                  state_q <= S_NRD;
                end else begin
                  res_stat_q <= ST_RANGE;
                  state_q    <= S_FIN;
                end
              end
              CMD_CLEAR: begin
                count_q <= '0;
                state_q <= S_FIN;
              end
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_NRD: begin
          res_name_q <= name_rdata;
          state_q    <= S_FIN;
        end
        S_SRCH: begin
          mid_q <= mid_c;
          if (lo_q < hi_q) begin
            state_q <= S_ORD;
          end else if (cmd_q == CMD_LOAD) begin
            idx_q   <= count_q;
            state_q <= S_SH;
          end else if (lo_q < count_q) begin
            fin_q   <= 1'b1;
            state_q <= S_ORD;
          end else begin
            res_stat_q <= ST_NOTFOUND;
            state_q    <= S_FIN;
          end
        end
        S_ORD: begin
          ordv_q  <= ord_rdata;
          state_q <= S_NAME;
        end
        S_NAME: state_q <= S_CMP;
        S_CMP: begin
          if (fin_q) begin
            if (cmp_res.eq) res_num_q  <= NumW'({1'b0, ordv_q} + (IW+1)'(1));
            else            res_stat_q <= ST_NOTFOUND;
            state_q <= S_FIN;
          end else begin
            // on load, equal names go after the existing ones
            if (cmp_res.lt || (cmd_q == CMD_LOAD && cmp_res.eq)) lo_q <= mid_q + CW'(1);
            else                                                 hi_q <= mid_q;
            state_q <= S_SRCH;
          end
        end
        S_SH: begin
          if (idx_q > lo_q) begin
            state_q <= S_SHWR;
          end else begin
            count_q   <= count_q + CW'(1);
            res_num_q <= NumW'(CMPW'(count_q) + CMPW'(1));
            state_q   <= S_FIN;
          end
        end
        S_SHWR: begin
          idx_q   <= idx_q - CW'(1);
          state_q <= S_SH;
        end
        S_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_stat_q  <= res_stat_q;
            out_num_q   <= res_num_q;
            out_name_q  <= res_name_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_stat_q;
  assign out_o.found_number = out_num_q;
  assign out_o.out_head     = out_name_q[NameW-1 -: 64];
  assign out_o.out_middle   = out_name_q[NameW-65 -: 64];
  assign out_o.out_tail     = out_name_q[31:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CMPW'(MaxEntries))
    else $error("entry count past table size");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("idle right after accepting a word");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> (lo_q <= hi_q) && (hi_q <= count_q))
    else $error("search window out of order");

  a_shift_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHWR |-> idx_q > lo_q && idx_q <= count_q)
    else $error("insert shift out of range");

endmodule
`default_nettype wire

// ===== rtl/core/tnid_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tnid_cmp import tnid_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NameW-1:0] a_i,
  input  wire logic [NameW-1:0] b_i,
  output cmp_res_t              res_o
);

  // names are packed first byte high, so an unsigned compare is strcmp order
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.lt <= (a_i < b_i);
      res_o.eq <= (a_i == b_i);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tnid_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tnid_mem import tnid_pkg::*; #(
  parameter int unsigned Depth = MaxEntriesDef,
  parameter int unsigned IdxW  = $clog2(MaxEntriesDef)
) (
  input  wire logic             clk_i,
  input  wire logic             name_we_i,
  input  wire logic [IdxW-1:0]  name_waddr_i,
  input  wire logic [NameW-1:0] name_wdata_i,
  input  wire logic             name_re_i,
  input  wire logic [IdxW-1:0]  name_raddr_i,
  output logic      [NameW-1:0] name_rdata_o,
  input  wire logic             ord_we_i,
  input  wire logic [IdxW-1:0]  ord_waddr_i,
  input  wire logic [IdxW-1:0]  ord_wdata_i,
  input  wire logic             ord_re_i,
  input  wire logic [IdxW-1:0]  ord_raddr_i,
  output logic      [IdxW-1:0]  ord_rdata_o
);

  logic [NameW-1:0] name_mem [Depth];
  logic [IdxW-1:0]  ord_mem  [Depth];

  always_ff @(posedge clk_i) begin
    if (name_we_i) name_mem[name_waddr_i] <= name_wdata_i;
    if (name_re_i) name_rdata_o <= name_mem[name_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we_i) ord_mem[ord_waddr_i] <= ord_wdata_i;
    if (ord_re_i) ord_rdata_o <= ord_mem[ord_raddr_i];
  end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import tnid_pkg::*;

  localparam int unsigned Depth    = MaxEntriesDef;
  localparam int unsigned PoolSize = 8;

  typedef struct {
    status_e         st;
    logic [NumW-1:0] num;
    logic [NameW-1:0] nm;
  } reply_t;

  typedef struct {
    cmd_e             cmd;
    logic [NameW-1:0] nm;
    logic [NumW-1:0]  idx;
    bit               typed;
    status_e          st;
    logic [NumW-1:0]  num;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tnid_in_if  in_if ();
  tnid_out_if out_if ();

  two_way_name_index_dictionary_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // dictionary image kept by the bench
  logic [NameW-1:0] dict_names [Depth];
  int               dict_order [$];
  int               dict_count;

  reply_t           reply_q [$];
  logic [NameW-1:0] name_pool [PoolSize];
  int               errors;
  int               send_idle;
  int               take_idle;
  int               words_in;
  int               words_out;
  int               hits;
  int               fulls;

  function automatic logic [NameW-1:0] trim_name(logic [NameW-1:0] raw);
    logic [NameW-1:0] r;
    bit               ended;
    r = '0;
    ended = 1'b0;
    for (int k = 0; k < FieldBytes; k++) begin
      if (k >= NameBytesDef || raw[NameW-1-8*k -: 8] == 8'd0) ended = 1'b1;
      if (!ended) r[NameW-1-8*k -: 8] = raw[NameW-1-8*k -: 8];
    end
    return r;
  endfunction

  // first sorted slot whose name is >= key, or > key when past_equal is set
  function automatic int slot_of(logic [NameW-1:0] key, bit past_equal);
    int lo;
    int hi;
    int mid;
    logic [NameW-1:0] probe;
    lo = 0;
    hi = dict_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      probe = dict_names[dict_order[mid]];
      if (probe < key || (past_equal && probe == key)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic reply_t dict_apply(cmd_e c, logic [NameW-1:0] raw,
                                        logic [NumW-1:0] idx);
    reply_t           r;
    logic [NameW-1:0] key;
    int               p;
    r.st = ST_OK;
    r.num = '0;
    r.nm = '0;
    case (c)
      CMD_LOAD: begin
        if (dict_count >= Depth) begin
          r.st = ST_FULL;
        end else begin
          key = trim_name(raw);
          dict_names[dict_count] = key;
          p = slot_of(key, 1'b1);
          dict_order.insert(p, dict_count);
          dict_count++;
          r.num = NumW'(dict_count);
        end
      end
      CMD_QNAME: begin
        key = trim_name(raw);
        p = slot_of(key, 1'b0);
        if (p < dict_count && dict_names[dict_order[p]] == key)
          r.num = NumW'(dict_order[p] + 1);
        else
          r.st = ST_NOTFOUND;
      end
      CMD_QNUM: begin
        if (idx == 0 || idx > dict_count) r.st = ST_RANGE;
        else r.nm = dict_names[idx - 1];
      end
      default: begin
        dict_count = 0;
        dict_order.delete();
      end
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [NameW-1:0] got, logic [NameW-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // one word to the block; typed rows carry their own expectation
  task automatic send_word(row_t w);
    reply_t r;
    if ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= w.cmd;
    in_if.name_head    <= w.nm[159:96];
    in_if.name_middle  <= w.nm[95:32];
    in_if.name_tail    <= w.nm[31:0];
    in_if.entry_number <= w.idx;
    do @(posedge clk_i); while (!in_if.ready);
    r = dict_apply(w.cmd, w.nm, w.idx);
    if (w.typed) begin
      r.st = w.st;
      r.num = w.num;
      r.nm = '0;
    end
    if (w.cmd == CMD_QNAME && r.st == ST_OK) hits++;
    if (r.st == ST_FULL) fulls++;
    reply_q.push_back(r);
    words_in++;
  endtask

  function automatic row_t mk(cmd_e c, logic [NameW-1:0] nm, logic [NumW-1:0] idx);
    row_t w;
    w.cmd = c;
    w.nm = nm;
    w.idx = idx;
    w.typed = 1'b0;
    w.st = ST_OK;
    w.num = '0;
    return w;
  endfunction

  function automatic row_t mk_typed(cmd_e c, logic [NameW-1:0] nm, logic [NumW-1:0] idx,
                                    status_e st, logic [NumW-1:0] num);
    row_t w;
    w = mk(c, nm, idx);
    w.typed = 1'b1;
    w.st = st;
    w.num = num;
    return w;
  endfunction

  function automatic logic [NameW-1:0] rand_name();
    logic [NameW-1:0] n;
    int               len;
    n = {$urandom, $urandom, $urandom, $urandom, $urandom};
    len = $urandom_range(FieldBytes, 0);
    // zero the bytes past the end half the time, else leave junk there
    if (len < FieldBytes) begin
      n[NameW-1-8*len -: 8] = 8'd0;
      if ($urandom_range(1)) n = trim_name(n);
    end
    return n;
  endfunction

  // a pool name, half the time with random junk written after its terminating zero
  function automatic logic [NameW-1:0] pool_pick();
    logic [NameW-1:0] n;
    bit               ended;
    n = name_pool[$urandom_range(PoolSize - 1)];
    if ($urandom_range(1)) begin
      ended = 1'b0;
      for (int k = 0; k < FieldBytes; k++) begin
        if (ended) n[NameW-1-8*k -: 8] = 8'($urandom);
        if (n[NameW-1-8*k -: 8] == 8'd0) ended = 1'b1;
      end
    end
    return n;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= take_idle);
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_out++;
      if (reply_q.size() == 0) begin
        report("unexpected word", {out_if.out_head, out_if.out_middle, out_if.out_tail},
               '0);
      end else begin
        want = reply_q.pop_front();
        if (out_if.status != want.st) report("status", out_if.status, want.st);
        if (out_if.found_number != want.num)
          report("found_number", out_if.found_number, want.num);
        if ({out_if.out_head, out_if.out_middle, out_if.out_tail} != want.nm)
          report("name", {out_if.out_head, out_if.out_middle, out_if.out_tail}, want.nm);
      end
    end
  end

  initial begin
    #20ms;
    $display("timeout: %0d words in, %0d out", words_in, words_out);
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_t             tbl [$];
    row_t             w;
    logic [NameW-1:0] ones;
    logic [NameW-1:0] a_junk;
    logic [NameW-1:0] a_other;
    int               pick;
    errors = 0;
    words_in = 0;
    words_out = 0;
    hits = 0;
    fulls = 0;
    dict_count = 0;
    send_idle = 20;
    take_idle = 61;
    in_if.valid        <= 1'b0;
    in_if.command      <= CMD_CLEAR;
    in_if.name_head    <= '0;
    in_if.name_middle  <= '0;
    in_if.name_tail    <= '0;
    in_if.entry_number <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ones    = '1;
    a_junk  = {8'h41, 8'h00, {18{8'hA5}}};
    a_other = {8'h41, 8'h00, {18{8'h5A}}};
    tbl.push_back(mk_typed(CMD_QNUM, '0, 11'd1, ST_RANGE, '0));
    tbl.push_back(mk_typed(CMD_QNAME, ones, '0, ST_NOTFOUND, '0));
    tbl.push_back(mk_typed(CMD_QNUM, '0, 11'd0, ST_RANGE, '0));
    tbl.push_back(mk_typed(CMD_LOAD, ones, '0, ST_OK, 11'd1));
    tbl.push_back(mk_typed(CMD_LOAD, '0, '0, ST_OK, 11'd2));
    tbl.push_back(mk_typed(CMD_LOAD, a_junk, '0, ST_OK, 11'd3));
    tbl.push_back(mk_typed(CMD_LOAD, a_other, '0, ST_OK, 11'd4));
    tbl.push_back(mk_typed(CMD_LOAD, {8'h80, 152'd1}, '0, ST_OK, 11'd5));
    tbl.push_back(mk(CMD_QNAME, a_other, '0));
    tbl.push_back(mk(CMD_QNAME, '0, '0));
    tbl.push_back(mk(CMD_QNAME, ones, '0));
    tbl.push_back(mk(CMD_QNAME, {8'h80, 152'd1}, '0));
    tbl.push_back(mk(CMD_QNAME, {8'h7F, 152'd0}, '0));
    tbl.push_back(mk(CMD_QNUM, '0, 11'd1));
    tbl.push_back(mk(CMD_QNUM, '0, 11'd2));
    tbl.push_back(mk(CMD_QNUM, '0, 11'd3));
    tbl.push_back(mk(CMD_QNUM, '0, 11'd5));
    tbl.push_back(mk_typed(CMD_QNUM, '0, 11'd6, ST_RANGE, '0));
    tbl.push_back(mk_typed(CMD_QNUM, '0, 11'd1024, ST_RANGE, '0));
    tbl.push_back(mk_typed(CMD_CLEAR, ones, 11'h7FF, ST_OK, '0));
    tbl.push_back(mk_typed(CMD_QNUM, '0, 11'd1, ST_RANGE, '0));
    tbl.push_back(mk_typed(CMD_QNAME, ones, '0, ST_NOTFOUND, '0));
    foreach (tbl[i]) send_word(tbl[i]);

    // fill with one name: equal names append at the end, so no shifting
    for (int i = 0; i < Depth; i++) send_word(mk(CMD_LOAD, a_junk, '0));
    send_word(mk_typed(CMD_LOAD, ones, '0, ST_FULL, '0));
    send_word(mk(CMD_QNAME, a_other, '0));
    send_word(mk(CMD_QNUM, '0, 11'd1024));
    send_word(mk_typed(CMD_CLEAR, '0, '0, ST_OK, '0));

    for (int i = 0; i < PoolSize; i++) name_pool[i] = trim_name(rand_name());
    for (int i = 0; i < 850; i++) begin
      if (i == 300) begin
        send_idle = 61;
        take_idle = 20;
      end else if (i == 575) begin
        send_idle = 0;
        take_idle = 0;
      end
      pick = $urandom_range(99);
      if (pick < 2) begin
        w = mk(CMD_CLEAR, rand_name(), 11'($urandom));
      end else if (pick < 42) begin
        w = mk(CMD_LOAD, ($urandom_range(3) != 0) ? pool_pick() : rand_name(), '0);
      end else if (pick < 77) begin
        w = mk(CMD_QNAME, ($urandom_range(4) != 0) ? pool_pick() : rand_name(), '0);
      end else begin
        w = mk(CMD_QNUM, rand_name(),
               ($urandom_range(4) != 0) ? 11'($urandom_range(dict_count + 1))
                                         : 11'($urandom_range(Depth)));
      end
      send_word(w);
    end
    in_if.valid <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (2200) @(posedge clk_i);

    $display("%0d words sent, %0d checked, %0d name hits, %0d full-table loads",
             words_in, words_out, hits, fulls);
    $display("covered empty, full and cleared tables, duplicate and padded names");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tnid_pkg.sv
rtl/core/tnid_if.sv
rtl/core/tnid_cmp.sv
rtl/core/tnid_mem.sv
rtl/core/two_way_name_index_dictionary_unit.sv
bench/tb.sv
